>>> rtl/svn_pkg.sv
// Shared types and constants of the smooth vertex normal block.
package svn_pkg;

  localparam int MaxVertices = 1024;
  localparam int IdxW        = $clog2(MaxVertices);
  localparam int CoordW      = 24;
  localparam int SumW        = 24;
  localparam int NormW       = 16;
  localparam int DiffW       = CoordW + 1;
  localparam int ProdW       = 2 * DiffW;
  localparam int CrossW      = ProdW + 1;
  localparam int QDepth      = 4;
  localparam int QPtrW       = $clog2(QDepth);
  localparam int QCntW       = $clog2(QDepth + 1);

  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_TRI  = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef struct packed {
    action_t                  kind;
    idx_t                     a;
    idx_t                     b;
    idx_t                     c;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec24_t;

  typedef enum logic [2:0] {
    U_IDLE, U_MAX, U_NORM, U_SQ, U_SQRT, U_DINIT, U_DIV, U_DONE
  } ustate_t;

  typedef enum logic [3:0] {
    B_IDLE, B_LOAD, B_TRD, B_DIFF, B_MUL, B_CSUB, B_TSTART, B_TWAIT,
    B_RMW_RD, B_RMW_WR, B_SRD, B_SCAP, B_SSTART, B_SWAIT, B_OUT
  } bstate_t;

endpackage

>>> rtl/smooth_vertex_normals.sv
// Top level of the smooth per-vertex normal block.
//
// Input channel (push/full): action 0 stores a vertex position and clears its
// normal sum, action 1 adds the unit face normal of triangle a,b,c to the sums
// of its three corners, action 2 reads one vertex normal; action 3 is dropped.
// Result channel (empty/pop): one transaction per read item, in order, with the
// sum of that vertex scaled to unit length in Q1.14 and zero_sum set when the
// sum was the zero vector.
// A four-entry queue sits between the input port and the sequencer, so items
// are taken while the back end works or a result waits to be popped.
// Read and triangle time is set by the scaling unit: a 31-step square root
// (two radicand bits per cycle) and a 15-step divide shared by all items.
// Reset empties the queue and the result register; the position and sum
// memories are not cleared, so the user must load each vertex before it is
// used; the block itself does not enforce this.
// If the receiver stalls, the finished result holds on the ports; the back end
// keeps running loads and triangles and waits only on the next read result.
module smooth_vertex_normals (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            action,
  input  svn_pkg::idx_t         vertex_a,
  input  svn_pkg::idx_t         vertex_b,
  input  svn_pkg::idx_t         vertex_c,
  input  logic signed [23:0]    coord_x,
  input  logic signed [23:0]    coord_y,
  input  logic signed [23:0]    coord_z,
  output logic                  empty,
  input  logic                  pop,
  output svn_pkg::idx_t         vertex_index,
  output logic signed [15:0]    normal_x,
  output logic signed [15:0]    normal_y,
  output logic signed [15:0]    normal_z,
  output logic                  zero_sum
);
  import svn_pkg::*;

  logic  q_valid;
  logic  deq;
  item_t q_item;

  svn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .action   (action),
    .vertex_a (vertex_a),
    .vertex_b (vertex_b),
    .vertex_c (vertex_c),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .coord_z  (coord_z),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .deq      (deq)
  );

  svn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .deq          (deq),
    .empty        (empty),
    .pop          (pop),
    .vertex_index (vertex_index),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .zero_sum     (zero_sum)
  );

endmodule

>>> rtl/svn_front.sv
// Front end: accepts items, drops unused actions, queues them for the back end.
module svn_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   action,
  input  svn_pkg::idx_t                vertex_a,
  input  svn_pkg::idx_t                vertex_b,
  input  svn_pkg::idx_t                vertex_c,
  input  logic signed [23:0]           coord_x,
  input  logic signed [23:0]           coord_y,
  input  logic signed [23:0]           coord_z,
  output logic                         q_valid,
  output svn_pkg::item_t               q_item,
  input  logic                         deq
);
  import svn_pkg::*;

  item_t            qmem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             enq;
  action_t          act;
  item_t            new_item;

  assign act      = action_t'(action);
  assign full     = (count == QCntW'(QDepth));
  assign enq      = push && !full && (act != ACT_NONE);
  assign q_valid  = (count != '0);
  assign q_item   = qmem[rd_ptr];

  always_comb begin
    new_item.kind = act;
    new_item.a    = vertex_a;
    new_item.b    = vertex_b;
    new_item.c    = vertex_c;
    new_item.x    = coord_x;
    new_item.y    = coord_y;
    new_item.z    = coord_z;
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      qmem[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) wr_ptr <= wr_ptr + 1'b1;
      if (deq) rd_ptr <= rd_ptr + 1'b1;
      if (enq && !deq) count <= count + 1'b1;
      else if (deq && !enq) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("queue count above depth");

endmodule

>>> rtl/svn_unit.sv
// Unit-length scaling: normalize shift, sum of squares, square root, divide.
module svn_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [svn_pkg::CrossW-1:0] vec_x,
  input  logic signed [svn_pkg::CrossW-1:0] vec_y,
  input  logic signed [svn_pkg::CrossW-1:0] vec_z,
  output logic                             busy,
  output logic                             done,
  output logic signed [svn_pkg::NormW-1:0]  q_x,
  output logic signed [svn_pkg::NormW-1:0]  q_y,
  output logic signed [svn_pkg::NormW-1:0]  q_z,
  output logic                             zero
);
  import svn_pkg::*;

  ustate_t           state, state_next;
  logic [CrossW-1:0] m [3];
  logic [CrossW-1:0] vin [3];
  logic              neg [3];
  logic [CrossW-1:0] top;
  logic [59:0]       prod;
  logic [61:0]       acc;
  logic [61:0]       sq_sh;
  logic [33:0]       rem;
  logic [35:0]       nrem;
  logic [35:0]       trial;
  logic [30:0]       root;
  logic [30:0]       drem [3];
  logic [14:0]       dlow [3];
  logic [14:0]       dq [3];
  logic [4:0]        cnt;
  logic [44:0]       num [3];
  logic [31:0]       dt [3];
  logic signed [NormW-1:0] qv [3];

  assign vin[0] = vec_x;
  assign vin[1] = vec_y;
  assign vin[2] = vec_z;
  assign busy   = (state != U_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= U_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      U_IDLE:  if (start) state_next = U_MAX;
      U_MAX:   state_next = U_NORM;
      U_NORM: begin
        if (top == '0) state_next = U_DONE;
        else if (top[CrossW-1:30] == '0 && top[29]) state_next = U_SQ;
      end
      U_SQ:    if (cnt == 5'd3) state_next = U_SQRT;
      U_SQRT:  if (cnt == 5'd30) state_next = U_DINIT;
      U_DINIT: state_next = U_DIV;
      U_DIV:   if (cnt == 5'd14) state_next = U_DONE;
      U_DONE: begin
        done       = 1'b1;
        state_next = U_IDLE;
      end
      default: state_next = U_IDLE;
    endcase
  end

  assign nrem  = {rem, sq_sh[61:60]};
  assign trial = {3'b000, root, 2'b01};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, m[i][29:0], 14'd0} + 45'(root[30:1]);
      dt[i]  = {drem[i], dlow[i][14]};
      qv[i]  = neg[i] ? -$signed({1'b0, dq[i]}) : $signed({1'b0, dq[i]});
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        zero <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          neg[i] <= vin[i][CrossW-1];
          m[i]   <= vin[i][CrossW-1] ? CrossW'(-vin[i]) : vin[i];
        end
      end
      U_MAX: begin
        top <= (m[0] > m[1]) ? ((m[0] > m[2]) ? m[0] : m[2])
                             : ((m[1] > m[2]) ? m[1] : m[2]);
      end
      U_NORM: begin
        cnt <= '0;
        acc <= '0;
        if (top == '0) begin
          zero <= 1'b1;
        end else if (top[CrossW-1:37] != '0) begin
          top <= top >> 8;
          for (int i = 0; i < 3; i++) m[i] <= m[i] >> 8;
        end else if (top[CrossW-1:30] != '0) begin
          top <= top >> 1;
          for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
        end else if (top[29:22] == '0) begin
          top <= top << 8;
          for (int i = 0; i < 3; i++) m[i] <= m[i] << 8;
        end else if (!top[29]) begin
          top <= top << 1;
          for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
        end
      end
      U_SQ: begin
        if (cnt != 5'd3) prod <= m[cnt[1:0]][29:0] * m[cnt[1:0]][29:0];
        if (cnt != 5'd0) acc <= acc + 62'(prod);
        if (cnt == 5'd3) begin
          sq_sh <= acc + 62'(prod);
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      U_SQRT: begin
        sq_sh <= sq_sh << 2;
        if (nrem >= trial) begin
          rem  <= 34'(nrem - trial);
          root <= {root[29:0], 1'b1};
        end else begin
          rem  <= nrem[33:0];
          root <= {root[29:0], 1'b0};
        end
        cnt <= (cnt == 5'd30) ? 5'd0 : cnt + 1'b1;
      end
      U_DINIT: begin
        for (int i = 0; i < 3; i++) begin
          drem[i] <= {1'b0, num[i][44:15]};
          dlow[i] <= num[i][14:0];
        end
        cnt <= '0;
      end
      U_DIV: begin
        for (int i = 0; i < 3; i++) begin
          dlow[i] <= dlow[i] << 1;
          if (dt[i] >= {1'b0, root}) begin
            drem[i] <= 31'(dt[i] - {1'b0, root});
            dq[i]   <= {dq[i][13:0], 1'b1};
          end else begin
            drem[i] <= dt[i][30:0];
            dq[i]   <= {dq[i][13:0], 1'b0};
          end
        end
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  assign q_x = zero ? '0 : qv[0];
  assign q_y = zero ? '0 : qv[1];
  assign q_z = zero ? '0 : qv[2];

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (q_x <= 16384 && q_x >= -16384 && q_y <= 16384 && q_y >= -16384
              && q_z <= 16384 && q_z >= -16384))
    else $error("unit normal component out of range");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (done && zero) |-> (q_x == '0 && q_y == '0 && q_z == '0))
    else $error("zero vector gave nonzero normal");

endmodule

>>> rtl/svn_back.sv
// Back end: position and sum memories, cross product, sum updates, result register.
module svn_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  svn_pkg::item_t            q_item,
  output logic                      deq,
  output logic                      empty,
  input  logic                      pop,
  output svn_pkg::idx_t             vertex_index,
  output logic signed [15:0]        normal_x,
  output logic signed [15:0]        normal_y,
  output logic signed [15:0]        normal_z,
  output logic                      zero_sum
);
  import svn_pkg::*;

  bstate_t                  state, state_next;
  item_t                    cur;
  logic [2:0]               cnt;
  vec24_t                   pos_mem [MaxVertices];
  vec24_t                   sum_mem [MaxVertices];
  vec24_t                   pos_rd, sum_rd, pos_wdata, sum_wdata;
  idx_t                     pos_addr, sum_addr, corner;
  logic                     pos_we, sum_we;
  vec24_t                   pa, pb, pc;
  logic signed [DiffW-1:0]  ab [3];
  logic signed [DiffW-1:0]  ac [3];
  logic signed [DiffW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0]  prod;
  logic signed [ProdW-1:0]  pr [6];
  logic signed [CrossW-1:0] uvec [3];
  logic signed [NormW-1:0]  n [3];
  logic signed [NormW-1:0]  res [3];
  logic                     res_zero;
  logic                     u_start, u_busy, u_done, u_zero;
  logic signed [NormW-1:0]  u_q [3];
  logic                     out_valid;
  logic                     out_load;

  function automatic logic signed [SumW-1:0] sat_add(
    input logic signed [SumW-1:0] s, input logic signed [NormW-1:0] v);
    logic signed [SumW:0] t;
    t = (SumW+1)'(s) + (SumW+1)'(v);
    if (t > (SumW+1)'(8388607))       sat_add = 24'sd8388607;
    else if (t < -(SumW+1)'(8388608)) sat_add = -24'sd8388608;
    else                              sat_add = t[SumW-1:0];
  endfunction

  svn_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (u_start),
    .vec_x (uvec[0]),
    .vec_y (uvec[1]),
    .vec_z (uvec[2]),
    .busy  (u_busy),
    .done  (u_done),
    .q_x   (u_q[0]),
    .q_y   (u_q[1]),
    .q_z   (u_q[2]),
    .zero  (u_zero)
  );

  always_comb begin
    case (cnt[1:0])
      2'd0:    corner = cur.a;
      2'd1:    corner = cur.b;
      default: corner = cur.c;
    endcase
  end

  always_comb begin
    case (cnt)
      3'd0:    begin mul_a = ab[1]; mul_b = ac[2]; end
      3'd1:    begin mul_a = ab[2]; mul_b = ac[1]; end
      3'd2:    begin mul_a = ab[2]; mul_b = ac[0]; end
      3'd3:    begin mul_a = ab[0]; mul_b = ac[2]; end
      3'd4:    begin mul_a = ab[0]; mul_b = ac[1]; end
      default: begin mul_a = ab[1]; mul_b = ac[0]; end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_addr] <= pos_wdata;
    pos_rd <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_addr] <= sum_wdata;
    sum_rd <= sum_mem[sum_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  assign out_load = (state == B_OUT) && (!out_valid || pop);

  always_comb begin
    state_next = state;
    deq        = 1'b0;
    u_start    = 1'b0;
    pos_we     = 1'b0;
    sum_we     = 1'b0;
    pos_addr   = corner;
    sum_addr   = corner;
    pos_wdata  = '{x: cur.x, y: cur.y, z: cur.z};
    sum_wdata  = '{x: sat_add(sum_rd.x, n[0]), y: sat_add(sum_rd.y, n[1]),
                   z: sat_add(sum_rd.z, n[2])};
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          deq = 1'b1;
          unique case (q_item.kind)
            ACT_LOAD: state_next = B_LOAD;
            ACT_TRI:  state_next = B_TRD;
            ACT_READ: state_next = B_SRD;
            default:  state_next = B_IDLE;
          endcase
        end
      end
      B_LOAD: begin
        pos_we     = 1'b1;
        sum_we     = 1'b1;
        pos_addr   = cur.a;
        sum_addr   = cur.a;
        sum_wdata  = '0;
        state_next = B_IDLE;
      end
      B_TRD:    if (cnt == 3'd3) state_next = B_DIFF;
      B_DIFF:   state_next = B_MUL;
      B_MUL:    if (cnt == 3'd6) state_next = B_CSUB;
      B_CSUB:   state_next = B_TSTART;
      B_TSTART: begin
        u_start    = 1'b1;
        state_next = B_TWAIT;
      end
      B_TWAIT:  if (u_done) state_next = B_RMW_RD;
      B_RMW_RD: state_next = B_RMW_WR;
      B_RMW_WR: begin
        sum_we     = 1'b1;
        state_next = (cnt == 3'd2) ? B_IDLE : B_RMW_RD;
      end
      B_SRD: begin
        sum_addr   = cur.a;
        state_next = B_SCAP;
      end
      B_SCAP:   state_next = B_SSTART;
      B_SSTART: begin
        u_start    = 1'b1;
        state_next = B_SWAIT;
      end
      B_SWAIT:  if (u_done) state_next = B_OUT;
      B_OUT:    if (!out_valid || pop) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        cur <= q_item;
        cnt <= '0;
      end
      B_TRD: begin
        if (cnt == 3'd1) pa <= pos_rd;
        if (cnt == 3'd2) pb <= pos_rd;
        if (cnt == 3'd3) pc <= pos_rd;
        cnt <= (cnt == 3'd3) ? 3'd0 : cnt + 1'b1;
      end
      B_DIFF: begin
        ab[0] <= DiffW'(pb.x) - DiffW'(pa.x);
        ab[1] <= DiffW'(pb.y) - DiffW'(pa.y);
        ab[2] <= DiffW'(pb.z) - DiffW'(pa.z);
        ac[0] <= DiffW'(pc.x) - DiffW'(pa.x);
        ac[1] <= DiffW'(pc.y) - DiffW'(pa.y);
        ac[2] <= DiffW'(pc.z) - DiffW'(pa.z);
      end
      B_MUL: begin
        prod <= mul_a * mul_b;
        if (cnt != 3'd0) pr[cnt - 3'd1] <= prod;
        cnt <= (cnt == 3'd6) ? 3'd0 : cnt + 1'b1;
      end
      B_CSUB: begin
        uvec[0] <= CrossW'(pr[0]) - CrossW'(pr[1]);
        uvec[1] <= CrossW'(pr[2]) - CrossW'(pr[3]);
        uvec[2] <= CrossW'(pr[4]) - CrossW'(pr[5]);
      end
      B_TWAIT: begin
        if (u_done) begin
          for (int i = 0; i < 3; i++) n[i] <= u_q[i];
        end
      end
      B_RMW_WR: cnt <= cnt + 1'b1;
      B_SCAP: begin
        uvec[0] <= CrossW'(sum_rd.x);
        uvec[1] <= CrossW'(sum_rd.y);
        uvec[2] <= CrossW'(sum_rd.z);
      end
      B_SWAIT: begin
        if (u_done) begin
          for (int i = 0; i < 3; i++) res[i] <= u_q[i];
          res_zero <= u_zero;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      vertex_index <= cur.a;
      normal_x     <= res[0];
      normal_y     <= res[1];
      normal_z     <= res[2];
      zero_sum     <= res_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)           out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (pop)      out_valid <= 1'b0;
  end

  assign empty = !out_valid;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    u_start |-> !u_busy)
    else $error("scaling unit started while busy");

endmodule
